/* src/kwsc_pkg.sv */
// Shared types and constants for the keyword substitution cipher.
// Used by kwsc_ctrl, kwsc_datapath and keyword_substitution_cipher_core.
package kwsc_pkg;

  localparam int ALPHA_SIZE = 26;
  localparam int LETTER_W   = 5;
  localparam int OP_W       = 3;
  localparam int CHAR_W     = 8;

  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHA_SIZE - 1);
  localparam logic [LETTER_W:0]   ALPHA_COUNT = (LETTER_W+1)'(ALPHA_SIZE);

  localparam logic [CHAR_W-1:0] ASCII_UA = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] ASCII_UZ = 8'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] ASCII_LA = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] ASCII_LZ = 8'h7A;  // 'z'
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  localparam logic [OP_W-1:0] OP_START   = 3'd0;
  localparam logic [OP_W-1:0] OP_KEY     = 3'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 3'd2;
  localparam logic [OP_W-1:0] OP_ENCRYPT = 3'd3;
  localparam logic [OP_W-1:0] OP_DECRYPT = 3'd4;

  typedef struct packed {
    logic clear;       // drop the current key
    logic key_wr;      // append a key character
    logic scan_start;  // rewind the finish walk
    logic scan;        // append the walk letter
    logic lookup;      // capture a message character and read the tables
    logic decrypt;     // lookup goes through the inverse table
    logic load_out;    // move the lookup result into the output register
  } kwsc_cmd_t;

  typedef struct packed {
    logic scan_done;   // walk is at the last letter
    logic out_busy;    // output register holds a result not yet taken
  } kwsc_stat_t;

endpackage

/* src/keyword_substitution_cipher_core.sv */
// Keyword substitution cipher over A-Z, top level.
// Depends on kwsc_pkg, kwsc_ctrl and kwsc_datapath.
//
// Usage:
//   s_* carries commands: op selects start key, key character, finish key,
//   encrypt or decrypt; char_in is the ASCII character. m_* returns one
//   result (char_out, mapped) for each encrypt or decrypt transaction.
//   Build a key with start, a run of key characters and a finish, then
//   stream message characters.
// Timing:
//   Start and key character transactions are acted on in the cycle they are taken.
//   Finish walks all 26 letters through the table write port, one a cycle,
//   and holds s_tready low until the walk reaches the last letter.
//   Encrypt/decrypt: the table memory read is registered, then the result
//   moves into the output register and m_tvalid rises; the move waits while
//   the output register holds a result the receiver has not taken.
// Reset clears the used-letter mask, fill count and output valid; the
// tables themselves are not cleared. When the receiver stalls, the held
// result stays on m_*; the next command is still taken, and a further
// lookup waits until the output register empties.
module keyword_substitution_cipher_core import kwsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [2:0] op, [10:3] char_in, [15:11] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] char_out, [8] mapped, [15:9] zero
);

  kwsc_cmd_t   cmd;
  kwsc_stat_t  stat;
  logic [CHAR_W-1:0] out_char;
  logic              out_mapped;

  kwsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tdata[OP_W-1:0]),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kwsc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_char    (s_tdata[OP_W+CHAR_W-1:OP_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (out_char),
    .out_mapped (out_mapped)
  );

  assign m_tdata = {7'b0, out_mapped, out_char};

  // at most one datapath action per cycle
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.key_wr, cmd.scan_start, cmd.scan, cmd.lookup, cmd.load_out}))
    else $error("conflicting datapath commands");

  // never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // finish walk blocks input
  a_fill_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !s_tready)
    else $error("input accepted during finish walk");

  // a lookup is followed by a busy cycle
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |=> (!s_tready && !cmd.lookup))
    else $error("input accepted while lookup pending");

endmodule

/* src/kwsc_ctrl.sv */
// Controller state machine for the keyword substitution cipher.
// Depends on kwsc_pkg; drives kwsc_datapath through kwsc_cmd_t.
module kwsc_ctrl import kwsc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  kwsc_stat_t      stat,
  output kwsc_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FILL   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       dec_pend;
  logic       dec_pend_next;
  logic       take;

  assign in_ready = (state == ST_IDLE);
  assign take     = in_ready && in_valid;

  always_comb begin
    state_next    = state;
    dec_pend_next = dec_pend;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          case (in_op)
            OP_START:  cmd.clear = 1'b1;
            OP_KEY:    cmd.key_wr = 1'b1;
            OP_FINISH: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_FILL;
            end
            OP_ENCRYPT, OP_DECRYPT: begin
              cmd.lookup    = 1'b1;
              cmd.decrypt   = (in_op == OP_DECRYPT);
              dec_pend_next = (in_op == OP_DECRYPT);
              state_next    = ST_RESULT;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESULT: begin
        cmd.decrypt = dec_pend;
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      dec_pend <= 1'b0;
    end else begin
      state    <= state_next;
      dec_pend <= dec_pend_next;
    end
  end

endmodule

/* src/kwsc_datapath.sv */
// Datapath for the keyword substitution cipher: key tables, used-letter
// mask, fill count, finish walk counter and output register. Uses kwsc_pkg.
module kwsc_datapath import kwsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  kwsc_cmd_t         cmd,
  output kwsc_stat_t        stat,
  input  logic [CHAR_W-1:0] in_char,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_mapped
);

  logic [LETTER_W-1:0] fwd_mem [0:ALPHA_SIZE-1];
  logic [LETTER_W-1:0] inv_mem [0:ALPHA_SIZE-1];

  logic [ALPHA_SIZE-1:0] letter_used;
  logic [LETTER_W:0]     fill_count;
  logic [LETTER_W-1:0]   scan_idx;

  logic [CHAR_W-1:0]   char_q;
  logic                hit_q;
  logic [LETTER_W-1:0] fwd_q;
  logic [LETTER_W-1:0] inv_q;

  logic [CHAR_W-1:0]   key_char;
  logic                key_letter;
  logic [CHAR_W-1:0]   key_ofs;
  logic                msg_letter;
  logic [CHAR_W-1:0]   msg_ofs;
  logic [LETTER_W-1:0] msg_idx;
  logic [LETTER_W-1:0] app_idx;
  logic                app_en;
  logic                app_wr;
  logic                msg_hit;
  logic [LETTER_W-1:0] res_idx;

  // fold lowercase key letters to uppercase
  always_comb begin
    key_char = in_char;
    if (in_char >= ASCII_LA && in_char <= ASCII_LZ) begin
      key_char = in_char - CASE_OFS;
    end
  end

  assign key_letter = (key_char >= ASCII_UA) && (key_char <= ASCII_UZ);
  assign key_ofs    = key_char - ASCII_UA;
  assign msg_letter = (in_char >= ASCII_UA) && (in_char <= ASCII_UZ);
  assign msg_ofs    = in_char - ASCII_UA;
  assign msg_idx    = msg_ofs[LETTER_W-1:0];

  assign app_idx = cmd.scan ? scan_idx : key_ofs[LETTER_W-1:0];
  assign app_en  = cmd.scan || (cmd.key_wr && key_letter);
  assign app_wr  = app_en && !letter_used[app_idx] && (fill_count < ALPHA_COUNT);

  assign msg_hit = msg_letter &&
                   (cmd.decrypt ? letter_used[msg_idx]
                                : ({1'b0, msg_idx} < fill_count));

  assign stat.scan_done = (scan_idx == LAST_LETTER);
  assign stat.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_used <= '0;
      fill_count  <= '0;
    end else if (cmd.clear) begin
      letter_used <= '0;
      fill_count  <= '0;
    end else if (app_wr) begin
      letter_used[app_idx] <= 1'b1;
      fill_count           <= fill_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan && !stat.scan_done) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // table memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (app_wr) begin
      fwd_mem[fill_count[LETTER_W-1:0]] <= app_idx;
      inv_mem[app_idx]                  <= fill_count[LETTER_W-1:0];
    end
    if (cmd.lookup) begin
      fwd_q <= fwd_mem[msg_idx];
      inv_q <= inv_mem[msg_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      char_q <= in_char;
      hit_q  <= msg_hit;
    end
  end

  assign res_idx = cmd.decrypt ? inv_q : fwd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_mapped <= hit_q;
      out_char   <= hit_q ? (ASCII_UA + {{(CHAR_W-LETTER_W){1'b0}}, res_idx}) : char_q;
    end
  end

endmodule
